// ===== rtl/ucs_pkg.sv =====
// ----------------------------------------------------------------------------
// ucs_pkg - URL component splitter shared types and constants
// Phase, part-tag, scheme-match and port sub-state encodings, plus
// character classes used by the splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ucs_pkg;

  typedef enum logic [3:0] {
    PH_SCH_FIRST  = 4'd0,
    PH_SCH_REST   = 4'd1,
    PH_COLON      = 4'd2,
    PH_SLASH1     = 4'd3,
    PH_HOST_FIRST = 4'd4,
    PH_HOST       = 4'd5,
    PH_V6         = 4'd6,
    PH_AFTER_V6   = 4'd7,
    PH_PORT       = 4'd8,
    PH_PATH       = 4'd9,
    PH_QUERY      = 4'd10,
    PH_FRAG       = 4'd11,
    PH_DEAD       = 4'd12
  } phase_t;

  typedef enum logic [2:0] {
    PT_SCHEME  = 3'd0,
    PT_DELIM   = 3'd1,
    PT_HOST    = 3'd2,
    PT_PORT    = 3'd3,
    PT_PATH    = 3'd4,
    PT_QUERY   = 3'd5,
    PT_FRAG    = 3'd6,
    PT_DISCARD = 3'd7
  } part_t;

  // progress of the "http" / "https" scheme match
  typedef enum logic [2:0] {
    SM_START = 3'd0,
    SM_H     = 3'd1,
    SM_HT    = 3'd2,
    SM_HTT   = 3'd3,
    SM_HTTP  = 3'd4,
    SM_HTTPS = 3'd5,
    SM_NONE  = 3'd6
  } smatch_t;

  // port text sub-state, stoi style
  typedef enum logic [1:0] {
    PS_WS     = 2'd0,
    PS_SIGN   = 2'd1,
    PS_DIGITS = 2'd2,
    PS_DONE   = 2'd3
  } psub_t;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_P  = 8'h70;
  localparam logic [7:0] CH_LC_S  = 8'h73;

  localparam logic [16:0] PORT_SAT     = 17'd65536;
  localparam logic [15:0] PORT_HTTP    = 16'd80;
  localparam logic [15:0] PORT_HTTPS   = 16'd443;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/url_component_splitter.sv =====
// ----------------------------------------------------------------------------
// url_component_splitter - streaming URL splitter
// Tags each URL byte by component and reports a per-URL summary on the
// last byte.
// ----------------------------------------------------------------------------
`default_nettype none

// One request carries one URL byte; the block answers with exactly one
// result per byte, one byte per clock while out_ready is held high. The byte
// is classified by a single level of logic against the parse-state registers
// and written into the result register, so the result appears the cycle
// after the request is taken; in_ready stays high while the result register
// is empty or being drained, so back-to-back bytes flow with no bubbles.
// Scheme bytes come out lower-cased. On the request flagged last, the result
// also carries validity, the port (parsed, or 80/443 for http/https) and
// whether the path defaulted to '/', and the parse state returns to its
// reset value so the next byte starts a new URL. The summary fields read
// zero on every other result.
module url_component_splitter
  import ucs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_last,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_ch_out,
  output logic [2:0]       out_part,
  output logic             out_done_res,
  output logic             out_valid_res,
  output logic             out_port_present,
  output logic [15:0]      out_port,
  output logic             out_path_defaulted
);

  // parse state
  phase_t      phase_r,         phase_nxt;
  logic        failed_r,        failed_nxt;
  smatch_t     smatch_r,        smatch_nxt;
  logic        host_ne_r,       host_ne_nxt;
  logic        bracketed_r,     bracketed_nxt;
  psub_t       psub_r,          psub_nxt;
  logic [16:0] pval_r,          pval_nxt;
  logic        perr_r,          perr_nxt;
  logic        port_seen_r,     port_seen_nxt;
  logic        path_seen_r,     path_seen_nxt;

  // result register
  logic        out_valid_r;
  logic [7:0]  ch_out_r,   ch_out_nxt;
  part_t       part_r,     part_nxt;
  logic        done_r;
  logic        vres_r,     vres_nxt;
  logic        ppres_r,    ppres_nxt;
  logic [15:0] port_r,     port_nxt;
  logic        pdef_r,     pdef_nxt;

  logic        accept;
  logic [7:0]  lc_ch;
  logic [19:0] pval_mul;   // value*10 + digit, before saturation
  logic        digit_step;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign lc_ch    = is_upper(in_ch) ? (in_ch + 8'd32) : in_ch;
  // times ten as two shifts and an add
  assign pval_mul = {pval_r, 3'b000} + {2'b00, pval_r, 1'b0} + {16'd0, in_ch[3:0]};

  always_comb begin
    phase_nxt     = phase_r;
    failed_nxt    = failed_r;
    smatch_nxt    = smatch_r;
    host_ne_nxt   = host_ne_r;
    bracketed_nxt = bracketed_r;
    psub_nxt      = psub_r;
    pval_nxt      = pval_r;
    perr_nxt      = perr_r;
    port_seen_nxt = port_seen_r;
    path_seen_nxt = path_seen_r;
    ch_out_nxt    = in_ch;
    part_nxt      = PT_DISCARD;
    vres_nxt      = 1'b0;
    ppres_nxt     = 1'b0;
    port_nxt      = 16'd0;
    pdef_nxt      = 1'b0;
    digit_step    = 1'b0;

    case (phase_r)
      PH_SCH_FIRST, PH_SCH_REST: begin
        if (phase_r == PH_SCH_REST && in_ch == CH_COLON) begin
          part_nxt  = PT_DELIM;
          phase_nxt = PH_COLON;
        end else if (is_alpha(in_ch) || (phase_r == PH_SCH_REST &&
                     (is_digit(in_ch) || in_ch == CH_PLUS ||
                      in_ch == CH_MINUS || in_ch == CH_DOT))) begin
          part_nxt   = PT_SCHEME;
          ch_out_nxt = lc_ch;
          phase_nxt  = PH_SCH_REST;
          case (smatch_r)
            SM_START: smatch_nxt = (lc_ch == CH_LC_H) ? SM_H     : SM_NONE;
            SM_H:     smatch_nxt = (lc_ch == CH_LC_T) ? SM_HT    : SM_NONE;
            SM_HT:    smatch_nxt = (lc_ch == CH_LC_T) ? SM_HTT   : SM_NONE;
            SM_HTT:   smatch_nxt = (lc_ch == CH_LC_P) ? SM_HTTP  : SM_NONE;
            SM_HTTP:  smatch_nxt = (lc_ch == CH_LC_S) ? SM_HTTPS : SM_NONE;
            default:  smatch_nxt = SM_NONE;
          endcase
        end else begin
          failed_nxt = 1'b1;
          phase_nxt  = PH_DEAD;
        end
      end
      PH_COLON, PH_SLASH1: begin
        if (in_ch == CH_SLASH) begin
          part_nxt  = PT_DELIM;
          phase_nxt = (phase_r == PH_COLON) ? PH_SLASH1 : PH_HOST_FIRST;
        end else begin
          failed_nxt = 1'b1;
          phase_nxt  = PH_DEAD;
        end
      end
      PH_HOST_FIRST, PH_HOST: begin
        if (in_ch == CH_SLASH) begin
          part_nxt      = PT_PATH;
          path_seen_nxt = 1'b1;
          phase_nxt     = PH_PATH;
        end else if (in_ch == CH_COLON) begin
          part_nxt      = PT_DELIM;
          port_seen_nxt = 1'b1;
          phase_nxt     = PH_PORT;
        end else if (phase_r == PH_HOST_FIRST && in_ch == CH_LBRK) begin
          part_nxt      = PT_DELIM;
          bracketed_nxt = 1'b1;
          phase_nxt     = PH_V6;
        end else begin
          part_nxt    = PT_HOST;
          host_ne_nxt = 1'b1;
          phase_nxt   = PH_HOST;
        end
      end
      PH_V6: begin
        if (in_ch == CH_RBRK) begin
          part_nxt  = PT_DELIM;
          phase_nxt = PH_AFTER_V6;
        end else if (in_ch == CH_SLASH) begin
          // slash inside brackets: unterminated IPv6 literal
          failed_nxt = 1'b1;
          phase_nxt  = PH_DEAD;
        end else begin
          part_nxt    = PT_HOST;
          host_ne_nxt = 1'b1;
        end
      end
      PH_AFTER_V6: begin
        if (in_ch == CH_COLON) begin
          part_nxt      = PT_DELIM;
          port_seen_nxt = 1'b1;
          phase_nxt     = PH_PORT;
        end else if (in_ch == CH_SLASH) begin
          part_nxt      = PT_PATH;
          path_seen_nxt = 1'b1;
          phase_nxt     = PH_PATH;
        end
      end
      PH_PORT: begin
        if (in_ch == CH_SLASH) begin
          if (psub_r == PS_WS || psub_r == PS_SIGN ||
              pval_r == 17'd0 || pval_r == PORT_SAT) begin
            perr_nxt = 1'b1;
          end
          part_nxt      = PT_PATH;
          path_seen_nxt = 1'b1;
          phase_nxt     = PH_PATH;
        end else begin
          part_nxt = PT_PORT;
          case (psub_r)
            PS_WS: begin
              if (is_space(in_ch)) begin
                // skip leading whitespace
              end else if (in_ch == CH_PLUS || in_ch == CH_MINUS) begin
                if (in_ch == CH_MINUS) perr_nxt = 1'b1;
                psub_nxt = PS_SIGN;
              end else begin
                digit_step = 1'b1;
              end
            end
            PS_SIGN, PS_DIGITS: digit_step = 1'b1;
            default: ;
          endcase
          if (digit_step) begin
            if (is_digit(in_ch)) begin
              pval_nxt = (pval_mul > {3'd0, PORT_SAT}) ? PORT_SAT : pval_mul[16:0];
              psub_nxt = PS_DIGITS;
            end else begin
              if (psub_r != PS_DIGITS) perr_nxt = 1'b1;
              psub_nxt = PS_DONE;
            end
          end
        end
      end
      PH_PATH: begin
        if (in_ch == CH_QUEST) begin
          part_nxt  = PT_DELIM;
          phase_nxt = PH_QUERY;
        end else if (in_ch == CH_HASH) begin
          part_nxt  = PT_DELIM;
          phase_nxt = PH_FRAG;
        end else begin
          part_nxt = PT_PATH;
        end
      end
      PH_QUERY: begin
        if (in_ch == CH_HASH) begin
          part_nxt  = PT_DELIM;
          phase_nxt = PH_FRAG;
        end else begin
          part_nxt = PT_QUERY;
        end
      end
      PH_FRAG:  part_nxt = PT_FRAG;
      default:  part_nxt = PT_DISCARD;
    endcase

    // end of URL: close out the port and build the summary
    if (in_last) begin
      if (phase_nxt == PH_PORT &&
          (psub_nxt == PS_WS || psub_nxt == PS_SIGN ||
           pval_nxt == 17'd0 || pval_nxt == PORT_SAT)) begin
        perr_nxt = 1'b1;
      end
      if (phase_nxt == PH_SCH_FIRST || phase_nxt == PH_SCH_REST ||
          phase_nxt == PH_COLON || phase_nxt == PH_SLASH1 || phase_nxt == PH_V6) begin
        failed_nxt = 1'b1;
      end
      if (!failed_nxt) begin
        vres_nxt = host_ne_nxt && !perr_nxt;
        pdef_nxt = !path_seen_nxt;
        if (port_seen_nxt) begin
          if (!perr_nxt) begin
            ppres_nxt = 1'b1;
            port_nxt  = pval_nxt[15:0];
          end
        end else if (smatch_nxt == SM_HTTP) begin
          ppres_nxt = 1'b1;
          port_nxt  = PORT_HTTP;
        end else if (smatch_nxt == SM_HTTPS) begin
          ppres_nxt = 1'b1;
          port_nxt  = PORT_HTTPS;
        end
      end
      // next byte starts a fresh URL
      phase_nxt     = PH_SCH_FIRST;
      failed_nxt    = 1'b0;
      smatch_nxt    = SM_START;
      host_ne_nxt   = 1'b0;
      bracketed_nxt = 1'b0;
      psub_nxt      = PS_WS;
      pval_nxt      = 17'd0;
      perr_nxt      = 1'b0;
      port_seen_nxt = 1'b0;
      path_seen_nxt = 1'b0;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SCH_FIRST;
      failed_r    <= 1'b0;
      smatch_r    <= SM_START;
      host_ne_r   <= 1'b0;
      bracketed_r <= 1'b0;
      psub_r      <= PS_WS;
      pval_r      <= 17'd0;
      perr_r      <= 1'b0;
      port_seen_r <= 1'b0;
      path_seen_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      failed_r    <= failed_nxt;
      smatch_r    <= smatch_nxt;
      host_ne_r   <= host_ne_nxt;
      bracketed_r <= bracketed_nxt;
      psub_r      <= psub_nxt;
      pval_r      <= pval_nxt;
      perr_r      <= perr_nxt;
      port_seen_r <= port_seen_nxt;
      path_seen_r <= path_seen_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded on every accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_out_r <= ch_out_nxt;
      part_r   <= part_nxt;
      done_r   <= in_last;
      vres_r   <= vres_nxt;
      ppres_r  <= ppres_nxt;
      port_r   <= port_nxt;
      pdef_r   <= pdef_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ch_out         = ch_out_r;
  assign out_part           = part_r;
  assign out_done_res       = done_r;
  assign out_valid_res      = vres_r;
  assign out_port_present   = ppres_r;
  assign out_port           = port_r;
  assign out_path_defaulted = pdef_r;

endmodule

`default_nettype wire
